// ----- design/ibrs_pkg.sv -----
// Shared widths, register indexes, constants and types for the imaging batch retry scheduler.
package ibrs_pkg;

  localparam int unsigned SECTOR_W  = 32;
  localparam int unsigned CNT_W     = 10;
  localparam int unsigned RETRY_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 32;

  localparam int unsigned BATCH_MAX_LIMIT_DEF = 512;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SECTORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BATCH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 2'd2;

  localparam logic [SECTOR_W-1:0] TOTAL_SECTORS_RST = '0;
  localparam logic [CNT_W-1:0]    MAX_BATCH_RST     = 10'd512;
  localparam logic [RETRY_W-1:0]  RETRY_LIMIT_RST   = 4'd5;

  localparam logic [SECTOR_W-1:0] READ6_MAX_START = 32'h00FF_FFFF;
  localparam logic [CNT_W-1:0]    READ6_MAX_COUNT = 10'd256;
  localparam logic [SECTOR_W-1:0] SECTOR_MAX      = '1;

  typedef struct packed {
    logic                finished;
    logic [SECTOR_W-1:0] next_start_sector;
    logic [CNT_W-1:0]    batch_count;
    logic                use_read10;
    logic                bus_reset_req;
    logic                sector_skipped;
    logic [RETRY_W-1:0]  retries_used;
  } out_word_t;

endpackage

// ----- design/imaging_batch_retry_scheduler_top.sv -----
// Top level of the imaging batch retry scheduler: input register, step logic, result register.
//
// Usage:
//   Each input word either starts a new drive (in_start_drive = 1) or reports the
//   outcome of the batch issued by the previous result (in_read_ok). Every input word
//   produces exactly one result word: the next batch to read (start sector, count,
//   READ6/READ10 choice) or the finished flag, plus bus-reset and skip indications.
//   Configuration (total sectors, maximum batch, retry limit) is written through the cfg_ port;
//   the user writes it only while no word is in flight (not enforced); it applies from the next input word.
// Timing:
//   A word accepted into the input register is evaluated from there into the result
//   register when that register can advance, and then shows on out_.
//   One word per cycle is sustained while out_stall is low; the step logic is a single
//   compare-add-select path from the input register and the state registers to the result register.
// Flow control:
//   When out_stall holds the result register full, the input register still takes one
//   more word; in_stall rises only when both registers are occupied and blocked.
// Reset:
//   rst_n low clears progress, retry count, single-sector range and the outstanding
//   batch, loads register defaults and empties both pipeline registers.
module imaging_batch_retry_scheduler_top #(
  parameter int unsigned BATCH_MAX_LIMIT = ibrs_pkg::BATCH_MAX_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ibrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ibrs_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_start_drive,
  input  logic                              in_read_ok,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_finished,
  output logic [ibrs_pkg::SECTOR_W-1:0]     out_next_start_sector,
  output logic [ibrs_pkg::CNT_W-1:0]        out_batch_count,
  output logic                              out_use_read10,
  output logic                              out_bus_reset_req,
  output logic                              out_sector_skipped,
  output logic [ibrs_pkg::RETRY_W-1:0]      out_retries_used
);

  localparam int unsigned SW = ibrs_pkg::SECTOR_W;
  localparam int unsigned CW = ibrs_pkg::CNT_W;
  localparam int unsigned RW = ibrs_pkg::RETRY_W;

  // Configuration registers.
  logic [SW-1:0] total_r;
  logic [CW-1:0] max_batch_r;
  logic [RW-1:0] retry_limit_r;

  // Scheduler state.
  logic [SW-1:0] done_r, done_nxt;
  logic [RW-1:0] retry_r, retry_nxt;
  logic [SW-1:0] single_until_r, single_until_nxt;
  logic [CW-1:0] last_batch_r, last_batch_nxt;

  // Pipeline registers.
  logic                s1_valid_r;
  logic                s1_start_r;
  logic                s1_ok_r;
  logic                out_valid_r;
  ibrs_pkg::out_word_t out_r, out_nxt;

  logic          advance;
  logic          fire;
  logic [SW:0]   sum_batch;
  logic [SW:0]   sum_one;
  logic [SW-1:0] sat_batch;
  logic [SW-1:0] sat_one;
  logic [CW-1:0] max_nz;
  logic [CW-1:0] eff_max;
  logic [SW-1:0] remaining;
  logic [CW-1:0] count;
  logic          finished;
  logic          reset_req;
  logic          skipped;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r       <= ibrs_pkg::TOTAL_SECTORS_RST;
      max_batch_r   <= ibrs_pkg::MAX_BATCH_RST;
      retry_limit_r <= ibrs_pkg::RETRY_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ibrs_pkg::CFG_TOTAL_SECTORS: total_r       <= cfg_wdata[SW-1:0];
        ibrs_pkg::CFG_MAX_BATCH:     max_batch_r   <= cfg_wdata[CW-1:0];
        ibrs_pkg::CFG_RETRY_LIMIT:   retry_limit_r <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // Saturating progress sums; both use the progress from before this word.
  assign sum_batch = {1'b0, done_r} + (SW+1)'(last_batch_r);
  assign sum_one   = {1'b0, done_r} + (SW+1)'(1'b1);
  assign sat_batch = sum_batch[SW] ? ibrs_pkg::SECTOR_MAX : sum_batch[SW-1:0];
  assign sat_one   = sum_one[SW] ? ibrs_pkg::SECTOR_MAX : sum_one[SW-1:0];

  // A zero maximum acts as one; anything above the build limit is clamped to it.
  assign max_nz  = (max_batch_r == '0) ? CW'(1) : max_batch_r;
  assign eff_max = (17'(max_nz) > 17'(BATCH_MAX_LIMIT)) ? CW'(BATCH_MAX_LIMIT) : max_nz;

  always_comb begin
    done_nxt         = done_r;
    retry_nxt        = retry_r;
    single_until_nxt = single_until_r;
    reset_req        = 1'b0;
    skipped          = 1'b0;
    if (s1_start_r) begin
      done_nxt         = '0;
      retry_nxt        = '0;
      single_until_nxt = '0;
    end else if (last_batch_r != '0) begin
      if (s1_ok_r) begin
        retry_nxt = '0;
        done_nxt  = sat_batch;
      end else if (retry_r < retry_limit_r) begin
        reset_req = 1'b1;
        retry_nxt = retry_r + RW'(1);
        // From the second failure of a multi-sector batch, fall back to single sectors.
        if (retry_r != '0 && last_batch_r > CW'(1)) begin
          single_until_nxt = sat_batch;
        end
      end else begin
        skipped   = 1'b1;
        retry_nxt = '0;
        done_nxt  = sat_one;
      end
    end
  end

  assign remaining = total_r - done_nxt;
  assign finished  = (done_nxt >= total_r);

  always_comb begin
    if (finished) begin
      count = '0;
    end else if (done_nxt < single_until_nxt) begin
      count = CW'(1);
    end else if (remaining > SW'(eff_max)) begin
      count = eff_max;
    end else begin
      count = remaining[CW-1:0];
    end
  end

  assign last_batch_nxt = count;

  always_comb begin
    out_nxt.finished          = finished;
    out_nxt.next_start_sector = done_nxt;
    out_nxt.batch_count       = count;
    out_nxt.use_read10        = !finished &&
                                !(done_nxt < ibrs_pkg::READ6_MAX_START &&
                                  count <= ibrs_pkg::READ6_MAX_COUNT);
    out_nxt.bus_reset_req     = reset_req;
    out_nxt.sector_skipped    = skipped;
    out_nxt.retries_used      = retry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      done_r         <= '0;
      retry_r        <= '0;
      single_until_r <= '0;
      last_batch_r   <= '0;
    end else begin
      if (!s1_valid_r || advance) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        done_r         <= done_nxt;
        retry_r        <= retry_nxt;
        single_until_r <= single_until_nxt;
        last_batch_r   <= last_batch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_start_r <= in_start_drive;
      s1_ok_r    <= in_read_ok;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_finished          = out_r.finished;
  assign out_next_start_sector = out_r.next_start_sector;
  assign out_batch_count       = out_r.batch_count;
  assign out_use_read10        = out_r.use_read10;
  assign out_bus_reset_req     = out_r.bus_reset_req;
  assign out_sector_skipped    = out_r.sector_skipped;
  assign out_retries_used      = out_r.retries_used;

endmodule

// ----- design/ibrs_checker.sv -----
// Port-level checker for the imaging batch retry scheduler and its bind statement.
module ibrs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_finished,
  input logic [ibrs_pkg::SECTOR_W-1:0]     out_next_start_sector,
  input logic [ibrs_pkg::CNT_W-1:0]        out_batch_count,
  input logic                              out_use_read10,
  input logic                              out_bus_reset_req,
  input logic                              out_sector_skipped,
  input logic [ibrs_pkg::RETRY_W-1:0]      out_retries_used
);

  // A finished word carries no batch and selects READ6.
  a_finished_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_batch_count == '0 && !out_use_read10)
    else $error("finished word carries a batch");

  // Any unfinished word issues at least one sector.
  a_batch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> out_batch_count != '0)
    else $error("empty batch issued while not finished");

  // A skip clears the retry count and is never paired with a bus-reset retry.
  a_skip_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sector_skipped |-> out_retries_used == '0 && !out_bus_reset_req)
    else $error("skip with retry pending");

  // A bus-reset retry always leaves a nonzero retry count.
  a_retry_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bus_reset_req |-> out_retries_used != '0)
    else $error("bus reset without retry count");

  // A stalled word holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_start_sector) &&
      $stable(out_batch_count))
    else $error("stalled word changed");

endmodule

bind imaging_batch_retry_scheduler_top ibrs_checker u_ibrs_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_finished          (out_finished),
  .out_next_start_sector (out_next_start_sector),
  .out_batch_count       (out_batch_count),
  .out_use_read10        (out_use_read10),
  .out_bus_reset_req     (out_bus_reset_req),
  .out_sector_skipped    (out_sector_skipped),
  .out_retries_used      (out_retries_used)
);
